// ===== src/sfhs_pkg.sv =====
// Package for the stepper full/half step sequencer.
// Holds the field widths, register defaults, coil tables and the shared state types.
// No dependencies.
package sfhs_pkg;

    localparam int DEBOUNCE_BITS = 16;
    localparam int FULL_PHASES   = 4;
    localparam int HALF_PHASES   = 8;
    localparam int INTERVAL_BITS = 16;
    localparam int FULL_PH_W     = $clog2(FULL_PHASES);
    localparam int HALF_PH_W     = $clog2(HALF_PHASES);
    localparam int NUM_BUTTONS   = 4;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 16;
    localparam int SAMPLE_W      = 8;
    localparam int S_TDATA_W     = 8;
    localparam int M_TDATA_W     = 32;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FULL_INT_A  = 3'd0,
        CFG_HALF_INT_A  = 3'd1,
        CFG_FULL_INT_B  = 3'd2,
        CFG_HALF_INT_B  = 3'd3,
        CFG_SPEED_DELTA = 3'd4,
        CFG_SPEED_FLOOR = 3'd5,
        CFG_SAMPLE_PER  = 3'd6,
        CFG_DEB_MATCH   = 3'd7
    } cfg_idx_t;

    // Button positions in the debouncer array and the item
    localparam int BTN_DIR    = 0;
    localparam int BTN_MODE   = 1;
    localparam int BTN_FASTER = 2;
    localparam int BTN_SLOWER = 3;

    typedef struct packed {
        logic [INTERVAL_BITS-1:0] full_interval_a;
        logic [INTERVAL_BITS-1:0] half_interval_a;
        logic [INTERVAL_BITS-1:0] full_interval_b;
        logic [INTERVAL_BITS-1:0] half_interval_b;
        logic [INTERVAL_BITS-1:0] speed_delta;
        logic [INTERVAL_BITS-1:0] speed_floor;
        logic [SAMPLE_W-1:0]      sample_period;
        logic [DEBOUNCE_BITS-1:0] debounce_match;
    } cfg_t;

    typedef struct packed {
        logic [FULL_PH_W-1:0]     full_phase;
        logic [HALF_PH_W-1:0]     half_phase;
        logic                     clockwise;
        logic                     full_mode;
        logic                     running_flag;
        logic                     profile;
        logic [INTERVAL_BITS-1:0] interval_ticks;
        logic [INTERVAL_BITS-1:0] tick_count;
        logic [SAMPLE_W-1:0]      sample_count;
        logic [NUM_BUTTONS-1:0][DEBOUNCE_BITS-1:0] debounce_shift;
        logic                     led_level;
        logic [3:0]               coil_hold;
    } seq_state_t;

    localparam cfg_t CFG_RESET = '{
        full_interval_a: INTERVAL_BITS'(1041),
        half_interval_a: INTERVAL_BITS'(520),
        full_interval_b: INTERVAL_BITS'(833),
        half_interval_b: INTERVAL_BITS'(416),
        speed_delta:     INTERVAL_BITS'(50),
        speed_floor:     INTERVAL_BITS'(55),
        sample_period:   SAMPLE_W'(5),
        debounce_match:  DEBOUNCE_BITS'(16'h7FFF)
    };

    localparam seq_state_t STATE_RESET = '{
        full_phase:     '0,
        half_phase:     '0,
        clockwise:      1'b1,
        full_mode:      1'b1,
        running_flag:   1'b0,
        profile:        1'b1,
        interval_ticks: '0,
        tick_count:     '0,
        sample_count:   '0,
        debounce_shift: '0,
        led_level:      1'b0,
        coil_hold:      4'h0
    };

    // Four-phase coil patterns, red gray yellow black with red as MSB
    function automatic logic [3:0] full_coils(input logic [FULL_PH_W-1:0] idx);
        logic [3:0] pat;
        case (idx)
            2'd0:    pat = 4'hA;
            2'd1:    pat = 4'h9;
            2'd2:    pat = 4'h5;
            2'd3:    pat = 4'h6;
            default: pat = 4'hA;
        endcase
        return pat;
    endfunction

    // Eight-phase coil patterns for half stepping
    function automatic logic [3:0] half_coils(input logic [HALF_PH_W-1:0] idx);
        logic [3:0] pat;
        case (idx)
            3'd0:    pat = 4'hA;
            3'd1:    pat = 4'h8;
            3'd2:    pat = 4'h9;
            3'd3:    pat = 4'h1;
            3'd4:    pat = 4'h5;
            3'd5:    pat = 4'h4;
            3'd6:    pat = 4'h6;
            3'd7:    pat = 4'h2;
            default: pat = 4'hA;
        endcase
        return pat;
    endfunction

endpackage

// ===== src/sfhs_step.sv =====
// Next-state logic for one tick of the stepper sequencer.
// Purely combinational; depends on sfhs_pkg for the state and configuration types.
module sfhs_step
    import sfhs_pkg::*;
(
    input  seq_state_t            cur,
    input  cfg_t                  cfg,
    input  logic [NUM_BUTTONS-1:0] btn_level,
    input  logic                  profile_press,
    output seq_state_t            nxt,
    output logic                  stepped
);

    logic [INTERVAL_BITS:0]   slow_sum;
    logic [INTERVAL_BITS-1:0] tick_inc;
    logic [SAMPLE_W-1:0]      samp_inc;
    logic [FULL_PH_W-1:0]     fph;
    logic [HALF_PH_W-1:0]     hph;
    logic [DEBOUNCE_BITS-1:0] shifted;
    logic                     fire;

    always_comb begin
        nxt      = cur;
        stepped  = 1'b0;
        slow_sum = '0;
        tick_inc = '0;
        samp_inc = '0;
        fph      = cur.full_phase;
        hph      = cur.half_phase;
        shifted  = '0;
        fire     = 1'b0;

        // Profile pulse: start if idle, toggle profile, reload interval
        if (profile_press) begin
            if (!nxt.running_flag) begin
                nxt.running_flag = 1'b1;
                nxt.clockwise    = 1'b1;
                nxt.full_mode    = 1'b1;
            end
            nxt.profile = ~nxt.profile;
            case ({nxt.profile, nxt.full_mode})
                2'b11:   nxt.interval_ticks = cfg.full_interval_a;
                2'b10:   nxt.interval_ticks = cfg.half_interval_a;
                2'b01:   nxt.interval_ticks = cfg.full_interval_b;
                default: nxt.interval_ticks = cfg.half_interval_b;
            endcase
            nxt.tick_count = '0;
        end

        if (nxt.running_flag) begin
            // Debouncer sampling; actions fire in button order within one sample
            samp_inc = nxt.sample_count + SAMPLE_W'(1);
            nxt.sample_count = samp_inc;
            if (samp_inc >= cfg.sample_period) begin
                nxt.sample_count = '0;
                for (int k = 0; k < NUM_BUTTONS; k++) begin
                    shifted = {nxt.debounce_shift[k][DEBOUNCE_BITS-2:0], ~btn_level[k]};
                    nxt.debounce_shift[k] = shifted;
                    fire = (shifted == cfg.debounce_match);
                    if (fire) begin
                        case (k)
                            BTN_DIR: begin
                                nxt.clockwise = ~nxt.clockwise;
                            end
                            BTN_MODE: begin
                                nxt.full_mode = ~nxt.full_mode;
                                case ({nxt.profile, nxt.full_mode})
                                    2'b11:   nxt.interval_ticks = cfg.full_interval_a;
                                    2'b10:   nxt.interval_ticks = cfg.half_interval_a;
                                    2'b01:   nxt.interval_ticks = cfg.full_interval_b;
                                    default: nxt.interval_ticks = cfg.half_interval_b;
                                endcase
                                nxt.tick_count = '0;
                            end
                            BTN_FASTER: begin
                                if (nxt.interval_ticks > cfg.speed_floor) begin
                                    if (cfg.speed_delta > nxt.interval_ticks) begin
                                        nxt.interval_ticks = '0;
                                    end else begin
                                        nxt.interval_ticks = nxt.interval_ticks - cfg.speed_delta;
                                    end
                                end
                                nxt.tick_count = '0;
                            end
                            default: begin
                                slow_sum = {1'b0, nxt.interval_ticks} + {1'b0, cfg.speed_delta};
                                if (slow_sum[INTERVAL_BITS]) begin
                                    nxt.interval_ticks = '1;
                                end else begin
                                    nxt.interval_ticks = slow_sum[INTERVAL_BITS-1:0];
                                end
                                nxt.tick_count = '0;
                            end
                        endcase
                    end
                end
            end

            // Step timer and coil sequencing, table read in reverse when clockwise
            tick_inc = nxt.tick_count + INTERVAL_BITS'(1);
            nxt.tick_count = tick_inc;
            if (tick_inc >= nxt.interval_ticks) begin
                nxt.tick_count = '0;
                stepped = 1'b1;
                if (nxt.full_mode) begin
                    fph = nxt.full_phase + FULL_PH_W'(1);
                    nxt.full_phase = fph;
                    nxt.coil_hold  = full_coils(nxt.clockwise ? ~fph : fph);
                end else begin
                    hph = nxt.half_phase + HALF_PH_W'(1);
                    nxt.half_phase = hph;
                    nxt.coil_hold  = half_coils(nxt.clockwise ? ~hph : hph);
                end
                nxt.led_level = ~nxt.led_level;
            end
        end
    end

endmodule

// ===== src/stepper_full_half_step_sequencer_top.sv =====
// Top level of the stepper full/half step sequencer: stream ports, configuration
// registers, sequencer state and the result register. Depends on sfhs_pkg and sfhs_step.
//
// Each input item is one millisecond tick carrying the four active-low button levels
// and the profile pulse; each accepted item yields exactly one result item. The block
// takes one item per clock cycle unless a result waits that the receiver does not take:
// the whole tick update is one pass of combinational logic from the state registers
// into the result register, so the result appears in the cycle after acceptance, and a
// new item is taken in the same cycle as a waiting result is taken. The configuration
// channel is always ready and its writes take effect from the next accepted item on.
module stepper_full_half_step_sequencer_top
    import sfhs_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // Input items
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // [0] button_dir_level, [1] button_mode_level, [2] button_faster_level,
    // [3] button_slower_level, [4] profile_press, [7:5] zero
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // Result items
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [3:0] coils, [4] step_taken, [5] step_led, [6] is_running, [7] is_clockwise,
    // [8] is_full_step, [9] profile_sel, [25:10] interval_now, [31:26] zero
    output logic [M_TDATA_W-1:0]  m_tdata,
    // Configuration writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t                 cfg_reg;
    seq_state_t           state_reg;
    seq_state_t           state_next;
    logic                 stepped;
    logic                 m_valid_reg;
    logic [M_TDATA_W-1:0] m_data_reg;
    logic [M_TDATA_W-1:0] m_data_next;
    logic                 in_accept;

    assign cfg_ready = 1'b1;
    assign s_tready  = !m_valid_reg || m_tready;
    assign in_accept = s_tvalid && s_tready;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;

    // Configuration register file
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_idx_t'(cfg_index))
                CFG_FULL_INT_A:  cfg_reg.full_interval_a <= cfg_data;
                CFG_HALF_INT_A:  cfg_reg.half_interval_a <= cfg_data;
                CFG_FULL_INT_B:  cfg_reg.full_interval_b <= cfg_data;
                CFG_HALF_INT_B:  cfg_reg.half_interval_b <= cfg_data;
                CFG_SPEED_DELTA: cfg_reg.speed_delta     <= cfg_data;
                CFG_SPEED_FLOOR: cfg_reg.speed_floor     <= cfg_data;
                CFG_SAMPLE_PER:  cfg_reg.sample_period   <= cfg_data[SAMPLE_W-1:0];
                CFG_DEB_MATCH:   cfg_reg.debounce_match  <= cfg_data;
                default:         cfg_reg <= cfg_reg;
            endcase
        end
    end

    // One tick of sequencer logic
    sfhs_step u_step (
        .cur           (state_reg),
        .cfg           (cfg_reg),
        .btn_level     (s_tdata[NUM_BUTTONS-1:0]),
        .profile_press (s_tdata[NUM_BUTTONS]),
        .nxt           (state_next),
        .stepped       (stepped)
    );

    // Result item packing
    assign m_data_next = {
        6'b0,
        state_next.interval_ticks,
        state_next.profile,
        state_next.full_mode,
        state_next.clockwise,
        state_next.running_flag,
        state_next.led_level,
        stepped,
        state_next.coil_hold
    };

    // Sequencer state advances once per accepted item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= STATE_RESET;
        end else if (in_accept) begin
            state_reg <= state_next;
        end
    end

    // Output register valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (in_accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // Output register payload
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            m_data_reg <= m_data_next;
        end
    end

endmodule

// ===== bench/sfhs_checker.sv =====
`timescale 1ns / 100ps
// Result checker for the stepper full/half step sequencer testbench.
// Follows the item, result and configuration channels, predicts every tick and
// compares each result item field by field. Depends on sfhs_pkg.
module sfhs_checker
    import sfhs_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    // [0] button_dir_level, [1] button_mode_level, [2] button_faster_level,
    // [3] button_slower_level, [4] profile_press, [7:5] zero
    input  logic [S_TDATA_W-1:0]  s_tdata,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    // [3:0] coils, [4] step_taken, [5] step_led, [6] is_running, [7] is_clockwise,
    // [8] is_full_step, [9] profile_sel, [25:10] interval_now, [31:26] zero
    input  logic [M_TDATA_W-1:0]  m_tdata,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    results_due,
    output int                    error_count
);

    // Result item laid out exactly as on m_tdata, most significant field first.
    typedef struct packed {
        logic [M_TDATA_W-INTERVAL_BITS-11:0] pad;
        logic [INTERVAL_BITS-1:0]            interval_now;
        logic                                profile_sel;
        logic                                is_full_step;
        logic                                is_clockwise;
        logic                                is_running;
        logic                                step_led;
        logic                                step_taken;
        logic [3:0]                          coils;
    } tick_result_t;

    // Coil patterns, entry 0 in the lowest nibble.
    localparam logic [FULL_PHASES-1:0][3:0] FULL_SEQ = {4'h6, 4'h5, 4'h9, 4'hA};
    localparam logic [HALF_PHASES-1:0][3:0] HALF_SEQ =
        {4'h2, 4'h6, 4'h4, 4'h5, 4'h1, 4'h9, 4'h8, 4'hA};

    // Own copy of the registers and the sequencer state.
    cfg_t                     regs;
    logic [FULL_PH_W-1:0]     full_ph;
    logic [HALF_PH_W-1:0]     half_ph;
    logic                     cw;
    logic                     full_step;
    logic                     running;
    logic                     prof_a;
    logic                     led;
    logic [INTERVAL_BITS-1:0] ival;
    logic [INTERVAL_BITS-1:0] ticks;
    logic [SAMPLE_W-1:0]      samples;
    logic [DEBOUNCE_BITS-1:0] shifts [NUM_BUTTONS];
    logic [3:0]               coils;
    tick_result_t             due_results [$];

    initial begin
        results_due = 0;
        error_count = 0;
    end

    // Interval for the current profile and step mode.
    function automatic logic [INTERVAL_BITS-1:0] profile_interval();
        case ({prof_a, full_step})
            2'b11:   return regs.full_interval_a;
            2'b10:   return regs.half_interval_a;
            2'b01:   return regs.full_interval_b;
            default: return regs.half_interval_b;
        endcase
    endfunction

    // Action of a debounced button; every action but direction restarts the timer.
    task automatic fire_button(input int btn);
        logic [INTERVAL_BITS:0] sum;
        case (btn)
            BTN_DIR: cw = ~cw;
            BTN_MODE: begin
                full_step = ~full_step;
                ival      = profile_interval();
                ticks     = '0;
            end
            BTN_FASTER: begin
                if (ival > regs.speed_floor)
                    ival = (regs.speed_delta > ival) ? '0 : ival - regs.speed_delta;
                ticks = '0;
            end
            default: begin
                sum   = {1'b0, ival} + regs.speed_delta;
                ival  = sum[INTERVAL_BITS] ? '1 : sum[INTERVAL_BITS-1:0];
                ticks = '0;
            end
        endcase
    endtask

    // One tick: profile pulse first, then button sampling, then the step timer.
    task automatic sequence_tick(input logic [4:0] item, output tick_result_t res);
        logic stepped;
        int   b;
        stepped = 1'b0;
        if (item[4]) begin
            if (!running) begin
                running   = 1'b1;
                cw        = 1'b1;
                full_step = 1'b1;
            end
            prof_a = ~prof_a;
            ival   = profile_interval();
            ticks  = '0;
        end
        if (running) begin
            samples = samples + 1'b1;
            if (samples >= regs.sample_period) begin
                samples = '0;
                for (b = 0; b < NUM_BUTTONS; b++) begin
                    shifts[b] = {shifts[b][DEBOUNCE_BITS-2:0], ~item[b]};
                    if (shifts[b] == regs.debounce_match)
                        fire_button(b);
                end
            end
            ticks = ticks + 1'b1;
            if (ticks >= ival) begin
                ticks   = '0;
                stepped = 1'b1;
                // Clockwise reads the table from the far end; the inverted phase
                // is the mirrored index.
                if (full_step) begin
                    full_ph = full_ph + 1'b1;
                    coils   = FULL_SEQ[cw ? ~full_ph : full_ph];
                end else begin
                    half_ph = half_ph + 1'b1;
                    coils   = HALF_SEQ[cw ? ~half_ph : half_ph];
                end
                led = ~led;
            end
        end
        res              = '0;
        res.coils        = coils;
        res.step_taken   = stepped;
        res.step_led     = led;
        res.is_running   = running;
        res.is_clockwise = cw;
        res.is_full_step = full_step;
        res.profile_sel  = prof_a;
        res.interval_now = ival;
    endtask

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endfunction

    // Results are matched before the item of the same edge is predicted, and
    // register writes count only from the next item on.
    always @(posedge aclk) begin
        tick_result_t got;
        tick_result_t want;
        if (!aresetn) begin
            regs      = CFG_RESET;
            full_ph   = '0;
            half_ph   = '0;
            cw        = 1'b1;
            full_step = 1'b1;
            running   = 1'b0;
            prof_a    = 1'b1;
            ival      = '0;
            ticks     = '0;
            samples   = '0;
            led       = 1'b0;
            coils     = '0;
            foreach (shifts[b]) shifts[b] = '0;
            due_results.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                if (due_results.size() == 0) begin
                    $error("result item %h arrived with none expected", m_tdata);
                    error_count++;
                end else begin
                    want = due_results.pop_front();
                    check_field("coils", want.coils, got.coils);
                    check_field("step_taken", want.step_taken, got.step_taken);
                    check_field("step_led", want.step_led, got.step_led);
                    check_field("is_running", want.is_running, got.is_running);
                    check_field("is_clockwise", want.is_clockwise, got.is_clockwise);
                    check_field("is_full_step", want.is_full_step, got.is_full_step);
                    check_field("profile_sel", want.profile_sel, got.profile_sel);
                    check_field("interval_now", want.interval_now, got.interval_now);
                    check_field("padding", want.pad, got.pad);
                end
            end
            if (s_tvalid && s_tready) begin
                sequence_tick(s_tdata[4:0], want);
                due_results.push_back(want);
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_idx_t'(cfg_index))
                    CFG_FULL_INT_A:  regs.full_interval_a = cfg_data;
                    CFG_HALF_INT_A:  regs.half_interval_a = cfg_data;
                    CFG_FULL_INT_B:  regs.full_interval_b = cfg_data;
                    CFG_HALF_INT_B:  regs.half_interval_b = cfg_data;
                    CFG_SPEED_DELTA: regs.speed_delta     = cfg_data;
                    CFG_SPEED_FLOOR: regs.speed_floor     = cfg_data;
                    CFG_SAMPLE_PER:  regs.sample_period   = cfg_data[SAMPLE_W-1:0];
                    default:         regs.debounce_match  = cfg_data;
                endcase
            end
        end
        results_due = due_results.size();
    end

endmodule

// ===== bench/stepper_full_half_step_sequencer_top_test.sv =====
`timescale 1ns / 100ps
// Testbench top for the stepper full/half step sequencer: clock, reset, tick and
// register stimulus with idling phases, and the verdict.
// Depends on sfhs_pkg, stepper_full_half_step_sequencer_top and sfhs_checker.
module stepper_full_half_step_sequencer_top_test;
    import sfhs_pkg::*;

    localparam int CYCLE_LIMIT     = 400000;
    localparam int NUM_PHASES      = 8;
    localparam int ITEMS_PER_PHASE = 205;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    int                    results_due;
    int                    error_count;

    // Idling rates in percent, and the one long hold-off of the receiver.
    int gap_pct         = 0;
    int stall_pct       = 0;
    int cur_period      = 1;
    bit long_hold_asked = 1'b0;
    bit long_hold_done  = 1'b0;

    stepper_full_half_step_sequencer_top u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    sfhs_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .results_due (results_due),
        .error_count (error_count)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // The run is cut off if it takes far longer than the slowest correct run.
    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("== FAIL ==");
        $finish;
    end

    // Receiver side: random stalls, plus one long hold-off on request.
    initial begin : result_sink
        int hold_left;
        hold_left = 0;
        forever begin
            @(negedge aclk);
            if (long_hold_asked && !long_hold_done) begin
                long_hold_done = 1'b1;
                hold_left      = 80;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // Offer one tick item after a random gap and hold it until it is taken.
    task automatic send_tick(input logic [3:0] levels, input logic press);
        @(negedge aclk);
        while ($urandom_range(99) < gap_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'({press, levels});
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    // Stop offering and wait until every result has come back.
    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        wait (results_due == 0);
        repeat (3) @(negedge aclk);
    endtask

    // Write one full set of registers; the fixed sets cover the extremes.
    task automatic apply_settings(input int which);
        logic [15:0] fa, ha, fb, hb, delta, speed_min, period, match;
        case (which)
            0: {fa, ha, fb, hb, delta, speed_min, period, match} =
                {16'd4, 16'd2, 16'd3, 16'd1, 16'd1, 16'd0, 16'd1, 16'h0001};
            1: {fa, ha, fb, hb, delta, speed_min, period, match} =
                {16'd1, 16'd1, 16'd1, 16'd1, 16'hFFFF, 16'd0, 16'd1, 16'h00FF};
            2: {fa, ha, fb, hb, delta, speed_min, period, match} =
                {16'hFFFF, 16'hFFFF, 16'd2, 16'd3, 16'd0, 16'hFFFF, 16'd255, 16'hFFFF};
            3: {fa, ha, fb, hb, delta, speed_min, period, match} =
                {16'd10, 16'd6, 16'd8, 16'd4, 16'd3, 16'd5, 16'd2, 16'h0000};
            4: {fa, ha, fb, hb, delta, speed_min, period, match} =
                {16'd7, 16'd5, 16'd9, 16'd3, 16'd2, 16'd1, 16'd1, 16'h7FFF};
            5: {fa, ha, fb, hb, delta, speed_min, period, match} =
                {16'd2, 16'd3, 16'hFFFE, 16'd1, 16'd40000, 16'd100, 16'd1, 16'h0003};
            default: begin
                fa        = 16'($urandom_range(1, 12));
                ha        = 16'($urandom_range(1, 12));
                fb        = 16'($urandom_range(1, 12));
                hb        = 16'($urandom_range(1, 12));
                delta     = 16'($urandom_range(0, 6));
                speed_min = 16'($urandom_range(0, 8));
                period    = 16'($urandom_range(1, 4));
                match     = (16'h1 << $urandom_range(1, 12)) - 16'h1;
            end
        endcase
        write_reg(CFG_FULL_INT_A, fa);
        write_reg(CFG_HALF_INT_A, ha);
        write_reg(CFG_FULL_INT_B, fb);
        write_reg(CFG_HALF_INT_B, hb);
        write_reg(CFG_SPEED_DELTA, delta);
        write_reg(CFG_SPEED_FLOOR, speed_min);
        write_reg(CFG_SAMPLE_PER, period);
        write_reg(CFG_DEB_MATCH, match);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        cur_period = period;
    endtask

    // Random ticks: mostly clean button holds long enough to pass the debouncers,
    // some bouncing noise, and the odd profile pulse.
    task automatic random_phase(input int phase);
        int         held [NUM_BUTTONS];
        logic [3:0] levels;
        logic       press;
        int         n;
        int         k;
        for (k = 0; k < NUM_BUTTONS; k++) held[k] = 0;
        for (n = 0; n < ITEMS_PER_PHASE; n++) begin
            if ($urandom_range(99) < 12) begin
                levels = 4'($urandom);
            end else begin
                for (k = 0; k < NUM_BUTTONS; k++) begin
                    if (held[k] > 0) begin
                        levels[k] = 1'b0;
                        held[k]--;
                    end else begin
                        levels[k] = 1'b1;
                        if ($urandom_range(39) == 0)
                            held[k] = $urandom_range(1, 20) * cur_period;
                    end
                end
            end
            press = ($urandom_range(59) == 0);
            send_tick(levels, press);
            // Fill the block up once, and pause once until it is empty.
            if (phase == 0 && n == 100)
                long_hold_asked = 1'b1;
            if (phase == 1 && n == 100)
                drain();
        end
    endtask

    initial begin : stimulus
        int phase;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Before the first pulse nothing may happen, whatever the buttons do.
        send_tick(4'h0, 1'b0);
        send_tick(4'hF, 1'b0);
        drain();
        apply_settings(0);

        // Start, then fire each button once on a fresh debouncer.
        send_tick(4'hF, 1'b1);
        send_tick(4'hE, 1'b0);
        send_tick(4'hD, 1'b0);
        send_tick(4'hB, 1'b0);
        send_tick(4'h7, 1'b0);
        send_tick(4'h0, 1'b0);
        send_tick(4'hF, 1'b1);
        repeat (8) send_tick(4'hF, 1'b0);
        send_tick(4'h0, 1'b1);
        send_tick(4'hA, 1'b0);
        send_tick(4'h5, 1'b0);
        drain();

        // Each phase has its own settings and its own way of idling.
        for (phase = 0; phase < NUM_PHASES; phase++) begin
            apply_settings(phase);
            case (phase % 4)
                0:       begin gap_pct = 0;  stall_pct = 0;  end
                1:       begin gap_pct = 88; stall_pct = 0;  end
                2:       begin gap_pct = 0;  stall_pct = 88; end
                default: begin gap_pct = 10; stall_pct = 10; end
            endcase
            random_phase(phase);
            drain();
        end

        if (error_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
